// ===== design/htms_pkg.sv =====
// ----------------------------------------------------------------------------
// htms_pkg
// Shared field widths, command codes and control structs for the handle
// table with mark and sweep bookkeeping.
// ----------------------------------------------------------------------------
package htms_pkg;

    // Field widths on the streaming ports
    localparam int MODE_W     = 3;
    localparam int HANDLE_W   = 10;
    localparam int KIND_W     = 8;
    localparam int TYPE_W     = 32;
    localparam int SIZE_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int FREED_W    = 11;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 96;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MARK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLR_MARKS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SWEEP     = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // Which result to build in the output register
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_ALLOC,
        RES_FULL,
        RES_DEAD,
        RES_LOOKUP,
        RES_FREED
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     in_load;     // capture the input fields
        logic     stack_rd;    // read the top of the free stack
        logic     alloc_new;   // allocate the next unused slot
        logic     alloc_pop;   // allocate the handle read from the stack
        logic     ent_rd;      // read entry and flags at the input handle
        logic     mark_set;    // set the mark at the input handle
        logic     walk_start;  // restart the slot walk and freed count
        logic     clr_step;    // clear one mark and advance the walk
        logic     sweep_rd;    // read flags at the walk index
        logic     sweep_step;  // keep or free the entry just read
        logic     res_load;    // load the output register
        res_sel_t res_sel;
    } htms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              stack_empty;
        logic              slot_avail;
        logic              walk_more;
        logic              live;
    } htms_sts_t;

endpackage

// ===== design/htms_datapath.sv =====
// ----------------------------------------------------------------------------
// htms_datapath
// Entry, flag and free stack memories, counters, input latch and the
// output result register.
// ----------------------------------------------------------------------------
module htms_datapath #(
    parameter int MAX_ENTRIES = 1024,
    parameter int KIND_BITS   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  htms_pkg::htms_cmd_t                cmd,
    input  logic [htms_pkg::MODE_W-1:0]        mode_in,
    input  logic [htms_pkg::HANDLE_W-1:0]      handle_in,
    input  logic [htms_pkg::KIND_W-1:0]        kind_in,
    input  logic [htms_pkg::TYPE_W-1:0]        type_in,
    input  logic [htms_pkg::SIZE_W-1:0]        size_in,
    output htms_pkg::htms_sts_t                sts,
    output logic [htms_pkg::STATUS_W-1:0]      status,
    output logic [htms_pkg::HANDLE_W-1:0]      handle_out,
    output logic [htms_pkg::KIND_W-1:0]        kind_out,
    output logic [htms_pkg::TYPE_W-1:0]        type_out,
    output logic [htms_pkg::SIZE_W-1:0]        size_out,
    output logic [htms_pkg::FREED_W-1:0]       freed_count
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int KW    = (KIND_BITS < htms_pkg::KIND_W) ? KIND_BITS : htms_pkg::KIND_W;
    localparam int ENT_W = KW + htms_pkg::TYPE_W + htms_pkg::SIZE_W;
    localparam int HX_W  = (IDX_W > htms_pkg::HANDLE_W) ? IDX_W : htms_pkg::HANDLE_W;
    localparam int HC_W  = (CNT_W > htms_pkg::HANDLE_W) ? CNT_W : htms_pkg::HANDLE_W;
    localparam int FX_W  = (CNT_W > htms_pkg::FREED_W) ? CNT_W : htms_pkg::FREED_W;

    // Memories
    logic [ENT_W-1:0] ent_mem   [MAX_ENTRIES];
    logic             alive_mem [MAX_ENTRIES];
    logic             mark_mem  [MAX_ENTRIES];
    logic [IDX_W-1:0] stack_mem [MAX_ENTRIES];

    // Input latch
    logic [htms_pkg::MODE_W-1:0]   mode_reg;
    logic [htms_pkg::HANDLE_W-1:0] handle_reg;
    logic [KW-1:0]                 kind_reg;
    logic [htms_pkg::TYPE_W-1:0]   type_reg;
    logic [htms_pkg::SIZE_W-1:0]   size_reg;

    // Counters
    logic [CNT_W-1:0] used_reg,  used_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] walk_reg,  walk_next;
    logic [CNT_W-1:0] freed_reg, freed_next;
    logic [IDX_W-1:0] h_reg,     h_next;

    // Read data
    logic [ENT_W-1:0] ent_rd_reg;
    logic             alive_rd_reg;
    logic             mark_rd_reg;
    logic [IDX_W-1:0] stack_rd_reg;

    // Result register
    logic [htms_pkg::STATUS_W-1:0] status_reg;
    logic [htms_pkg::HANDLE_W-1:0] handle_out_reg;
    logic [htms_pkg::KIND_W-1:0]   kind_out_reg;
    logic [htms_pkg::TYPE_W-1:0]   type_out_reg;
    logic [htms_pkg::SIZE_W-1:0]   size_out_reg;
    logic [htms_pkg::FREED_W-1:0]  freed_out_reg;

    logic [HX_W-1:0]  handle_ext;
    logic [HX_W-1:0]  h_ext;
    logic [FX_W-1:0]  freed_ext;
    logic [IDX_W-1:0] handle_addr;
    logic [IDX_W-1:0] walk_addr;
    logic [CNT_W-1:0] depth_m1;
    logic             in_range;
    logic             alloc;
    logic             sweep_free;
    logic             push;

    logic             alive_we;
    logic [IDX_W-1:0] alive_wa;
    logic             mark_we;
    logic [IDX_W-1:0] mark_wa;
    logic             flag_re;
    logic [IDX_W-1:0] flag_ra;

    // Addresses and compares
    always_comb
    begin
        handle_ext  = HX_W'(handle_reg);
        handle_addr = handle_ext[IDX_W-1:0];
        walk_addr   = walk_reg[IDX_W-1:0];
        depth_m1    = depth_reg - CNT_W'(1);
        in_range    = HC_W'(handle_reg) < HC_W'(used_reg);
        alloc       = cmd.alloc_new | cmd.alloc_pop;
        h_next      = cmd.alloc_pop ? stack_rd_reg : used_reg[IDX_W-1:0];
        sweep_free  = cmd.sweep_step & alive_rd_reg & ~mark_rd_reg;
        push        = sweep_free & (depth_reg < CNT_W'(MAX_ENTRIES));
        h_ext       = HX_W'(h_reg);
        freed_ext   = FX_W'(freed_reg);
    end

    // Memory write and read port selection
    always_comb
    begin
        alive_we = alloc | sweep_free;
        alive_wa = alloc ? h_next : walk_addr;
        mark_we  = alloc | cmd.mark_set | cmd.clr_step | (cmd.sweep_step & alive_rd_reg);
        if (alloc)
        begin
            mark_wa = h_next;
        end
        else if (cmd.mark_set)
        begin
            mark_wa = handle_addr;
        end
        else
        begin
            mark_wa = walk_addr;
        end
        flag_re = cmd.ent_rd | cmd.sweep_rd;
        flag_ra = cmd.ent_rd ? handle_addr : walk_addr;
    end

    // Counter updates
    always_comb
    begin
        used_next  = used_reg;
        depth_next = depth_reg;
        walk_next  = walk_reg;
        freed_next = freed_reg;
        if (cmd.alloc_new)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        if (cmd.alloc_pop)
        begin
            depth_next = depth_m1;
        end
        else if (push)
        begin
            depth_next = depth_reg + CNT_W'(1);
        end
        if (cmd.walk_start)
        begin
            walk_next  = '0;
            freed_next = '0;
        end
        else
        begin
            if (cmd.clr_step || cmd.sweep_step)
            begin
                walk_next = walk_reg + CNT_W'(1);
            end
            if (sweep_free)
            begin
                freed_next = freed_reg + CNT_W'(1);
            end
        end
    end

    // Hold counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            depth_reg <= '0;
            walk_reg  <= '0;
            freed_reg <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            depth_reg <= depth_next;
            walk_reg  <= walk_next;
            freed_reg <= freed_next;
        end
    end

    // Capture input fields and the granted handle
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            mode_reg   <= mode_in;
            handle_reg <= handle_in;
            kind_reg   <= kind_in[KW-1:0];
            type_reg   <= type_in;
            size_reg   <= size_in;
        end
        if (alloc)
        begin
            h_reg <= h_next;
        end
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            ent_mem[h_next] <= {size_reg, type_reg, kind_reg};
        end
        if (cmd.ent_rd)
        begin
            ent_rd_reg <= ent_mem[handle_addr];
        end
    end

    // Alive flag memory
    always_ff @(posedge clk)
    begin
        if (alive_we)
        begin
            alive_mem[alive_wa] <= alloc;
        end
        if (flag_re)
        begin
            alive_rd_reg <= alive_mem[flag_ra];
        end
    end

    // Mark flag memory
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= cmd.mark_set;
        end
        if (flag_re)
        begin
            mark_rd_reg <= mark_mem[flag_ra];
        end
    end

    // Free stack memory
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= walk_addr;
        end
        if (cmd.stack_rd)
        begin
            stack_rd_reg <= stack_mem[depth_m1[IDX_W-1:0]];
        end
    end

    // Build the result
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg     <= htms_pkg::STATUS_OK;
            handle_out_reg <= '0;
            kind_out_reg   <= '0;
            type_out_reg   <= '0;
            size_out_reg   <= '0;
            freed_out_reg  <= '0;
            case (cmd.res_sel)
                htms_pkg::RES_ALLOC:  handle_out_reg <= h_ext[htms_pkg::HANDLE_W-1:0];
                htms_pkg::RES_FULL:   status_reg     <= htms_pkg::STATUS_FULL;
                htms_pkg::RES_DEAD:   status_reg     <= htms_pkg::STATUS_DEAD;
                htms_pkg::RES_LOOKUP:
                begin
                    kind_out_reg <= htms_pkg::KIND_W'(ent_rd_reg[KW-1:0]);
                    type_out_reg <= ent_rd_reg[KW +: htms_pkg::TYPE_W];
                    size_out_reg <= ent_rd_reg[KW + htms_pkg::TYPE_W +: htms_pkg::SIZE_W];
                end
                htms_pkg::RES_FREED:  freed_out_reg  <= freed_ext[htms_pkg::FREED_W-1:0];
                default:              status_reg     <= htms_pkg::STATUS_OK;
            endcase
        end
    end

    // Status toward the controller
    always_comb
    begin
        sts.mode        = mode_reg;
        sts.stack_empty = (depth_reg == '0);
        sts.slot_avail  = used_reg < CNT_W'(MAX_ENTRIES);
        sts.walk_more   = walk_reg < used_reg;
        sts.live        = in_range & alive_rd_reg;
    end

    assign status      = status_reg;
    assign handle_out  = handle_out_reg;
    assign kind_out    = kind_out_reg;
    assign type_out    = type_out_reg;
    assign size_out    = size_out_reg;
    assign freed_count = freed_out_reg;

endmodule

// ===== design/htms_ctrl.sv =====
// ----------------------------------------------------------------------------
// htms_ctrl
// Command sequencer: takes one item at a time, steps the datapath through
// the memory accesses of its mode and hands the result to the output.
// ----------------------------------------------------------------------------
module htms_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  htms_pkg::htms_sts_t     sts,
    output htms_pkg::htms_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_POP,
        S_LOOK,
        S_CLR,
        S_SW_RD,
        S_SW_WR,
        S_FIN
    } state_t;

    state_t              state_reg,     state_next;
    htms_pkg::res_sel_t  res_sel_reg,   res_sel_next;
    logic                out_valid_reg, out_valid_next;
    logic                slot_free;

    // Sequence the item
    always_comb
    begin
        cmd            = '0;
        cmd.res_sel    = res_sel_reg;
        state_next     = state_reg;
        res_sel_next   = res_sel_reg;
        slot_free      = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.mode) inside
                    htms_pkg::MODE_ALLOC:
                    begin
                        if (!sts.stack_empty)
                        begin
                            cmd.stack_rd = 1'b1;
                            state_next   = S_ALLOC_POP;
                        end
                        else if (sts.slot_avail)
                        begin
                            cmd.alloc_new = 1'b1;
                            res_sel_next  = htms_pkg::RES_ALLOC;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            res_sel_next = htms_pkg::RES_FULL;
                            state_next   = S_FIN;
                        end
                    end
                    htms_pkg::MODE_LOOKUP, htms_pkg::MODE_MARK:
                    begin
                        cmd.ent_rd = 1'b1;
                        state_next = S_LOOK;
                    end
                    htms_pkg::MODE_CLR_MARKS:
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_CLR;
                    end
                    htms_pkg::MODE_SWEEP:
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_SW_RD;
                    end
                    default:
                    begin
                        res_sel_next = htms_pkg::RES_ZERO;
                        state_next   = S_FIN;
                    end
                endcase
            end
            S_ALLOC_POP:
            begin
                cmd.alloc_pop = 1'b1;
                res_sel_next  = htms_pkg::RES_ALLOC;
                state_next    = S_FIN;
            end
            S_LOOK:
            begin
                // Entry and flags are in the read registers now
                if (sts.mode == htms_pkg::MODE_LOOKUP)
                begin
                    res_sel_next = sts.live ? htms_pkg::RES_LOOKUP : htms_pkg::RES_DEAD;
                end
                else
                begin
                    cmd.mark_set = sts.live;
                    res_sel_next = sts.live ? htms_pkg::RES_ZERO : htms_pkg::RES_DEAD;
                end
                state_next = S_FIN;
            end
            S_CLR:
            begin
                if (sts.walk_more)
                begin
                    cmd.clr_step = 1'b1;
                end
                else
                begin
                    res_sel_next = htms_pkg::RES_ZERO;
                    state_next   = S_FIN;
                end
            end
            S_SW_RD:
            begin
                if (sts.walk_more)
                begin
                    cmd.sweep_rd = 1'b1;
                    state_next   = S_SW_WR;
                end
                else
                begin
                    res_sel_next = htms_pkg::RES_FREED;
                    state_next   = S_FIN;
                end
            end
            S_SW_WR:
            begin
                cmd.sweep_step = 1'b1;
                state_next     = S_SW_RD;
            end
            S_FIN:
            begin
                // Wait for the output register to empty
                if (slot_free)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_sel_reg   <= htms_pkg::RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_sel_reg   <= res_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/handle_table_mark_sweep.sv =====
// ----------------------------------------------------------------------------
// handle_table_mark_sweep
// Object handle table with a LIFO free stack and mark and sweep
// bookkeeping; one result per command.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                       Contents
//  s_axis    in         tvalid tready tdata tuser     command item
//  m_axis    out        tvalid tready tdata tuser     result item
//
//  Items are taken one at a time; the next item is accepted once the result
//  of the last is loaded. An allocate pops the free stack when it holds a
//  handle and otherwise takes a fresh slot; reset_marks and sweep walk every
//  slot ever used.
//  The walks are set by the flag memories: one entry per cycle to clear marks,
//  and a flag read and then a keep or free step per entry to sweep.
//  Reset clears the counters and control only; no clearing pass is needed.
//  A stalled result waits in the output register while the next item is
//  taken; that item finishes only once the register has emptied.
// ----------------------------------------------------------------------------
module handle_table_mark_sweep #(
    parameter int MAX_ENTRIES = 1024,
    parameter int KIND_BITS   = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // handle[9:0], kind[17:10], type_id[49:18], size_words[81:50], zero fill
    input  logic [htms_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // mode[2:0]
    input  logic [htms_pkg::MODE_W-1:0]           s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // handle_out[9:0], kind_out[17:10], type_out[49:18], size_out[81:50],
    // freed_count[92:82], zero fill
    output logic [htms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status[1:0]
    output logic [htms_pkg::STATUS_W-1:0]         m_axis_tuser
);

    htms_pkg::htms_cmd_t cmd;
    htms_pkg::htms_sts_t sts;

    logic [htms_pkg::HANDLE_W-1:0] handle_out;
    logic [htms_pkg::KIND_W-1:0]   kind_out;
    logic [htms_pkg::TYPE_W-1:0]   type_out;
    logic [htms_pkg::SIZE_W-1:0]   size_out;
    logic [htms_pkg::FREED_W-1:0]  freed_count;

    // Sequencer
    htms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage and result
    htms_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KIND_BITS   (KIND_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode_in     (s_axis_tuser),
        .handle_in   (s_axis_tdata[9:0]),
        .kind_in     (s_axis_tdata[17:10]),
        .type_in     (s_axis_tdata[49:18]),
        .size_in     (s_axis_tdata[81:50]),
        .sts         (sts),
        .status      (m_axis_tuser),
        .handle_out  (handle_out),
        .kind_out    (kind_out),
        .type_out    (type_out),
        .size_out    (size_out),
        .freed_count (freed_count)
    );

    // Pack the result transfer
    assign m_axis_tdata = {3'b000, freed_count, size_out, type_out, kind_out, handle_out};

    // The output register is loaded only when it is empty or draining
    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a waiting result");

    // A pop commits the handle read from the stack in the cycle before
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_pop |-> $past(cmd.stack_rd))
        else $error("free stack pop without a stack read");

    // A sweep decision follows the flag read of the same entry
    a_sweep_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_step |-> $past(cmd.sweep_rd))
        else $error("sweep step without a flag read");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

endmodule

// ===== dv/handle_table_mark_sweep_checker.sv =====
// ----------------------------------------------------------------------------
// handle_table_mark_sweep_checker
// Watches the command and result streams of the handle table, keeps its own
// copy of the table, free stack and mark bits, and compares every result
// transfer with the response predicted for the oldest pending command.
// ----------------------------------------------------------------------------
module handle_table_mark_sweep_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [htms_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [htms_pkg::MODE_W-1:0]     s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [htms_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [htms_pkg::STATUS_W-1:0]   m_axis_tuser,
    output int unsigned                     fail_count,
    output int unsigned                     pending_count
);

    localparam int NUM_SLOTS   = 1024;
    localparam int RESP_DATA_W = htms_pkg::FREED_W + htms_pkg::SIZE_W + htms_pkg::TYPE_W
                                 + htms_pkg::KIND_W + htms_pkg::HANDLE_W;

    // One response, laid out as status on top of the result tdata bits
    typedef struct packed {
        logic [htms_pkg::STATUS_W-1:0] status;
        logic [htms_pkg::FREED_W-1:0]  freed;
        logic [htms_pkg::SIZE_W-1:0]   size;
        logic [htms_pkg::TYPE_W-1:0]   type_id;
        logic [htms_pkg::KIND_W-1:0]   kind;
        logic [htms_pkg::HANDLE_W-1:0] handle;
    } table_resp_t;

    // Shadow of the handle table
    logic [htms_pkg::KIND_W-1:0]   slot_kind    [NUM_SLOTS];
    logic [htms_pkg::TYPE_W-1:0]   slot_type    [NUM_SLOTS];
    logic [htms_pkg::SIZE_W-1:0]   slot_size    [NUM_SLOTS];
    bit                            slot_alive   [NUM_SLOTS];
    bit                            slot_marked  [NUM_SLOTS];
    logic [htms_pkg::HANDLE_W-1:0] free_handles [NUM_SLOTS];
    int unsigned                   free_top;
    int unsigned                   slots_used;

    table_resp_t  expected_resp_q [$];
    table_resp_t  want;
    table_resp_t  got;
    int unsigned  mismatches;

    // Apply one command to the shadow table and return its response
    function automatic table_resp_t apply_command(
        input logic [htms_pkg::MODE_W-1:0]   mode,
        input logic [htms_pkg::HANDLE_W-1:0] hdl,
        input logic [htms_pkg::KIND_W-1:0]   kd,
        input logic [htms_pkg::TYPE_W-1:0]   tid,
        input logic [htms_pkg::SIZE_W-1:0]   sz
    );
        table_resp_t resp;
        int unsigned slot;
        int unsigned freed;
        bit          granted;
        bit          live;
        resp    = '0;
        granted = 1'b0;
        slot    = 0;
        freed   = 0;
        live    = (hdl < slots_used) && slot_alive[hdl];
        case (mode)
            htms_pkg::MODE_ALLOC:
            begin
                // Reuse the most recently freed handle before a fresh slot
                if (free_top > 0)
                begin
                    free_top = free_top - 1;
                    slot     = 32'(free_handles[free_top]);
                    granted  = 1'b1;
                end
                else if (slots_used < NUM_SLOTS)
                begin
                    slot       = slots_used;
                    slots_used = slots_used + 1;
                    granted    = 1'b1;
                end
                if (granted)
                begin
                    slot_kind[slot]   = kd;
                    slot_type[slot]   = tid;
                    slot_size[slot]   = sz;
                    slot_alive[slot]  = 1'b1;
                    slot_marked[slot] = 1'b0;
                    resp.handle       = htms_pkg::HANDLE_W'(slot);
                end
                else
                begin
                    resp.status = htms_pkg::STATUS_FULL;
                end
            end
            htms_pkg::MODE_LOOKUP:
            begin
                if (live)
                begin
                    resp.kind    = slot_kind[hdl];
                    resp.type_id = slot_type[hdl];
                    resp.size    = slot_size[hdl];
                end
                else
                begin
                    resp.status = htms_pkg::STATUS_DEAD;
                end
            end
            htms_pkg::MODE_MARK:
            begin
                if (live)
                    slot_marked[hdl] = 1'b1;
                else
                    resp.status = htms_pkg::STATUS_DEAD;
            end
            htms_pkg::MODE_CLR_MARKS:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    slot_marked[i] = 1'b0;
            end
            htms_pkg::MODE_SWEEP:
            begin
                // Keep marked entries and clear their marks, free unmarked live ones in slot order
                for (int i = 0; i < slots_used; i++)
                begin
                    if (slot_alive[i])
                    begin
                        if (slot_marked[i])
                        begin
                            slot_marked[i] = 1'b0;
                        end
                        else
                        begin
                            slot_alive[i] = 1'b0;
                            slot_type[i]  = '0;
                            slot_size[i]  = '0;
                            if (free_top < NUM_SLOTS)
                            begin
                                free_handles[free_top] = htms_pkg::HANDLE_W'(i);
                                free_top = free_top + 1;
                            end
                            freed = freed + 1;
                        end
                    end
                end
                resp.freed = htms_pkg::FREED_W'(freed);
            end
            default:
            begin
                // Unknown modes answer ok with all fields zero
            end
        endcase
        return resp;
    endfunction

    // Compare result transfers, then predict command transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_alive[i]  = 1'b0;
                slot_marked[i] = 1'b0;
            end
            free_top   = 0;
            slots_used = 0;
            mismatches = 0;
            expected_resp_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[RESP_DATA_W-1:0]};
                if (expected_resp_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] result transfer with no command pending: status %0d",
                                 $realtime, got.status);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_resp_q.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("  exp: status %0d handle %0d kind %02h type %08h size %08h freed %0d",
                                     want.status, want.handle, want.kind, want.type_id,
                                     want.size, want.freed);
                            $display("  got: status %0d handle %0d kind %02h type %08h size %08h freed %0d",
                                     got.status, got.handle, got.kind, got.type_id,
                                     got.size, got.freed);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = apply_command(s_axis_tuser,
                                     s_axis_tdata[9:0],
                                     s_axis_tdata[17:10],
                                     s_axis_tdata[49:18],
                                     s_axis_tdata[81:50]);
                expected_resp_q = {expected_resp_q, want};
            end
            fail_count    <= mismatches;
            pending_count <= expected_resp_q.size();
        end
    end

endmodule

// ===== dv/handle_table_mark_sweep_tb.sv =====
// ----------------------------------------------------------------------------
// handle_table_mark_sweep_tb
// Drives commands into the handle table under several idle and stall
// patterns: a directed opening, random command mixes with mostly small
// handles, a long receiver hold-off, then a fill to table full and sweeps
// over the whole table. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module handle_table_mark_sweep_tb;

    localparam int PHASE_ITEMS    = 215;
    localparam int FILL_ITEMS     = 1040;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [htms_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [htms_pkg::MODE_W-1:0]     s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [htms_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [htms_pkg::STATUS_W-1:0]   m_axis_tuser;
    int unsigned                     fail_count;
    int unsigned                     pending_count;

    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    logic        hold_req   = 1'b0;
    logic        hold_taken = 1'b0;
    int unsigned hold_cnt   = 0;
    int unsigned quiet_cycles = 0;

    handle_table_mark_sweep i_dut (.*);

    handle_table_mark_sweep_checker i_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: one long hold-off on request, otherwise random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
            hold_taken    <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken    <= 1'b1;
            hold_cnt      <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stop the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("handle_table_mark_sweep_tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Zero, all ones or a random word
    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return '0;
        else if (sel < 16)
            return '1;
        else
            return $urandom;
    endfunction

    // Offer one command and hold it until the transfer
    task automatic issue_cmd(
        input logic [htms_pkg::MODE_W-1:0]   mode,
        input logic [htms_pkg::HANDLE_W-1:0] hdl,
        input logic [htms_pkg::KIND_W-1:0]   kd,
        input logic [htms_pkg::TYPE_W-1:0]   tid,
        input logic [htms_pkg::SIZE_W-1:0]   sz
    );
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, sz, tid, kd, hdl};
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Random command, biased toward the low handles that are actually live
    task automatic issue_random_cmd();
        int unsigned                   sel;
        logic [htms_pkg::MODE_W-1:0]   mode;
        logic [htms_pkg::HANDLE_W-1:0] hdl;
        sel = $urandom_range(99);
        if (sel < 34)
            mode = htms_pkg::MODE_ALLOC;
        else if (sel < 56)
            mode = htms_pkg::MODE_LOOKUP;
        else if (sel < 78)
            mode = htms_pkg::MODE_MARK;
        else if (sel < 83)
            mode = htms_pkg::MODE_CLR_MARKS;
        else if (sel < 92)
            mode = htms_pkg::MODE_SWEEP;
        else
            mode = htms_pkg::MODE_W'($urandom_range(5, 7));
        sel = $urandom_range(99);
        if (sel < 70)
            hdl = htms_pkg::HANDLE_W'($urandom_range(0, 31));
        else if (sel < 90)
            hdl = htms_pkg::HANDLE_W'($urandom_range(0, 127));
        else
            hdl = htms_pkg::HANDLE_W'($urandom);
        issue_cmd(mode, hdl, htms_pkg::KIND_W'(pick_word()), pick_word(), pick_word());
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, unknown modes, edge values, free and reuse
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_MARK, 10'h3FF, 8'hFF, '1, '1);
        issue_cmd(3'd5, 10'h3FF, 8'hFF, '1, '1);
        issue_cmd(3'd6, 10'h3FF, 8'hFF, '1, '1);
        issue_cmd(3'd7, 10'h3FF, 8'hFF, '1, '1);
        issue_cmd(htms_pkg::MODE_ALLOC, 10'h3FF, 8'hFF, '1, '1);
        issue_cmd(htms_pkg::MODE_ALLOC, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_ALLOC, 10'd0, 8'h5A, 32'h1234_5678, 32'h8765_4321);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd1, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd2, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd3, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_MARK, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_MARK, 10'd2, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_SWEEP, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd1, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_MARK, 10'd1, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_ALLOC, 10'd0, 8'hC3, 32'hDEAD_BEEF, 32'h0000_0001);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd1, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_MARK, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_CLR_MARKS, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_SWEEP, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_ALLOC, 10'd0, 8'h81, 32'h8000_0000, 32'h7FFF_FFFF);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'd2, 8'h00, 32'h0, 32'h0);

        // Random mixes; the long receiver hold-off lands in the first phase
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct   = 0;
                    stall_pct <= 0;
                    hold_req  <= 1'b1;
                end
                1:
                begin
                    idle_pct   = 57;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct   = 0;
                    stall_pct <= 57;
                end
                default:
                begin
                    idle_pct   = 24;
                    stall_pct <= 24;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue_random_cmd();
        end

        // Fill the table past full, then sweep over every slot
        for (int n = 0; n < FILL_ITEMS; n++)
            issue_cmd(htms_pkg::MODE_ALLOC, htms_pkg::HANDLE_W'($urandom),
                      htms_pkg::KIND_W'(pick_word()), pick_word(), pick_word());
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'h3FF, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_MARK, 10'h3FF, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_CLR_MARKS, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_SWEEP, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_ALLOC, 10'd0, 8'hFF, '1, '1);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'h3FF, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_MARK, 10'h3FF, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_SWEEP, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_SWEEP, 10'd0, 8'h00, 32'h0, 32'h0);
        issue_cmd(htms_pkg::MODE_LOOKUP, 10'h3FF, 8'h00, 32'h0, 32'h0);

        // Drain outstanding results with the receiver always ready
        s_axis_tvalid <= 1'b0;
        stall_pct     <= 0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("handle_table_mark_sweep_tb passed");
        else
            $display("handle_table_mark_sweep_tb failed");
        $finish;
    end

endmodule
